@@ design/round_robin_time_slice_scheduler_assert.svh @@
// Assertion macros shared by the scheduler modules.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

@@ design/rrts_pkg.sv @@
// Shared types and constants of the round-robin time-slice scheduler.
package rrts_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned TASK_W        = 4;
  localparam int unsigned TASK_SLOTS    = 16;
  localparam int unsigned SLICE_W       = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
  localparam logic [TASK_W-1:0]  IDLE_RESET  = 4'd0;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ENQUEUE  = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_RESCHED  = 3'd3,
    OP_SWITCH   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_LENGTH = 1'd0,
    CFG_IDLE_TASK    = 1'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SW_PUSH,
    S_SW_SELECT,
    S_SW_POP,
    S_RM_READ,
    S_RM_CMP,
    S_SH_READ,
    S_SH_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic sw_push;
    logic sw_select;
    logic sw_pop;
    logic rm_read;
    logic rm_next;
    logic rm_miss;
    logic sh_read;
    logic sh_write;
    logic sh_finish;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic resched;
    logic match;
    logic scan_end;
    logic shift_end;
    logic queue_empty;
  } dp_sts_t;

endpackage

@@ design/rrts_ctrl.sv @@
// Controller state machine of the scheduler: sequences each request.
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.op == OP_REMOVE) begin
          state_d = S_RM_READ;
        end else if (sts_i.op == OP_SWITCH && sts_i.resched) begin
          state_d = S_SW_PUSH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SW_PUSH:   state_d = S_SW_SELECT;
      S_SW_SELECT: state_d = sts_i.queue_empty ? S_DONE : S_SW_POP;
      S_SW_POP:    state_d = S_DONE;
      S_RM_READ:   state_d = sts_i.scan_end ? S_DONE : S_RM_CMP;
      S_RM_CMP:    state_d = sts_i.match ? S_SH_READ : S_RM_READ;
      S_SH_READ:   state_d = sts_i.shift_end ? S_DONE : S_SH_WRITE;
      S_SH_WRITE:  state_d = S_SH_READ;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_EXEC:      cmd_o.exec      = 1'b1;
      S_SW_PUSH:   cmd_o.sw_push   = 1'b1;
      S_SW_SELECT: cmd_o.sw_select = 1'b1;
      S_SW_POP:    cmd_o.sw_pop    = 1'b1;
      S_RM_READ: begin
        cmd_o.rm_miss = sts_i.scan_end;
        cmd_o.rm_read = !sts_i.scan_end;
      end
      S_RM_CMP:    cmd_o.rm_next   = !sts_i.match;
      S_SH_READ: begin
        cmd_o.sh_finish = sts_i.shift_end;
        cmd_o.sh_read   = !sts_i.shift_end;
      end
      S_SH_WRITE:  cmd_o.sh_write  = 1'b1;
      S_DONE:      cmd_o.out_load  = out_free;
      default:     cmd_o           = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `include "round_robin_time_slice_scheduler_assert.svh"

  `RRTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `RRTS_ASSERT_NEXT(a_result_shown, cmd_o.out_load, out_valid_o)
  `RRTS_ASSERT_SAME(a_load_only_on_accept, cmd_o.load_item, in_valid_i && in_ready_o)

endmodule

@@ design/rrts_dp.sv @@
// Datapath of the scheduler: ready queue memory, slice counters and result register.
module rrts_dp
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [2:0]            operation_i,
  input  logic [TASK_W-1:0]     task_id_i,
  input  logic                  current_runnable_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output logic [TASK_W-1:0]     running_task_o,
  output logic                  switched_o,
  output logic                  resched_pending_o,
  output logic [1:0]            status_o
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW:0]   MAX_EXT  = (CW + 1)'(MAX_TASKS);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_TASKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

  logic [TASK_W-1:0] queue_mem_q [MAX_TASKS];
  logic [TASK_W-1:0] rd_data_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [TASK_W-1:0] wr_data;

  logic [SLICE_W-1:0] slice_q [TASK_SLOTS];
  logic [SLICE_W-1:0] slice_length_q;
  logic [TASK_W-1:0]  idle_task_q;

  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     head_q, head_d;
  logic [TASK_W-1:0] cur_q, cur_d;
  logic              resched_q, resched_d;

  op_e               op_q;
  logic [TASK_W-1:0] tid_q;
  logic              runnable_q;
  logic [CW-1:0]     k_q, k_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  status_e           status_q, status_d;
  logic              switched_q, switched_d;

  logic              full;
  logic              empty;
  logic [CW:0]       tail_sum;
  logic [CW:0]       tail_wrap;
  logic [IW-1:0]     tail;
  logic [IW-1:0]     head_inc;
  logic [IW-1:0]     ptr_inc;
  logic              push_cur;
  logic [SLICE_W-1:0] slice_cur;
  logic              slice_expire;
  logic              tick_we;

  assign full      = (count_q == MAX_CNT);
  assign empty     = (count_q == '0);
  assign tail_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign tail_wrap = (tail_sum >= MAX_EXT) ? (tail_sum - MAX_EXT) : tail_sum;
  assign tail      = tail_wrap[IW-1:0];
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
  assign ptr_inc   = (ptr_q == LAST_IDX) ? '0 : ptr_q + IW'(1);
  assign push_cur  = runnable_q && (cur_q != idle_task_q);

  assign slice_cur    = slice_q[cur_q];
  assign slice_expire = (slice_cur <= SLICE_W'(1));
  assign tick_we      = cmd_i.exec && (op_q == OP_TICK);

  assign sts_o.op          = op_q;
  assign sts_o.resched     = resched_q;
  assign sts_o.match       = (rd_data_q == tid_q);
  assign sts_o.scan_end    = (k_q == count_q);
  assign sts_o.shift_end   = ((CW + 1)'(k_q) + (CW + 1)'(1)) >= (CW + 1)'(count_q);
  assign sts_o.queue_empty = empty;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = tid_q;
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    if (cmd_i.exec && op_q == OP_ENQUEUE && !full) begin
      wr_en = 1'b1;
    end
    if (cmd_i.sw_push && push_cur && !full) begin
      wr_en   = 1'b1;
      wr_data = cur_q;
    end
    if (cmd_i.sh_write) begin
      wr_en   = 1'b1;
      wr_addr = ptr_q;
      wr_data = rd_data_q;
    end
    if (cmd_i.sw_select && !empty) begin
      rd_en   = 1'b1;
      rd_addr = head_q;
    end
    if (cmd_i.rm_read) begin
      rd_en = 1'b1;
    end
    if (cmd_i.sh_read) begin
      rd_en   = 1'b1;
      rd_addr = ptr_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= queue_mem_q[rd_addr];
    end
  end

  always_comb begin
    count_d    = count_q;
    head_d     = head_q;
    cur_d      = cur_q;
    resched_d  = resched_q;
    k_d        = k_q;
    ptr_d      = ptr_q;
    status_d   = status_q;
    switched_d = switched_q;
    if (cmd_i.load_item) begin
      k_d        = '0;
      ptr_d      = head_q;
      status_d   = ST_OK;
      switched_d = 1'b0;
    end
    if (cmd_i.exec) begin
      case (op_q)
        OP_TICK: begin
          if (slice_expire) resched_d = 1'b1;
        end
        OP_ENQUEUE: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        OP_RESCHED: resched_d = 1'b1;
        default:    resched_d = resched_q;
      endcase
    end
    if (cmd_i.sw_push) begin
      resched_d = 1'b0;
      if (push_cur) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
    end
    if (cmd_i.sw_select && empty) begin
      cur_d      = idle_task_q;
      switched_d = (idle_task_q != cur_q);
    end
    if (cmd_i.sw_pop) begin
      cur_d      = rd_data_q;
      switched_d = (rd_data_q != cur_q);
      head_d     = head_inc;
      count_d    = count_q - CW'(1);
    end
    if (cmd_i.rm_next) begin
      k_d   = k_q + CW'(1);
      ptr_d = ptr_inc;
    end
    if (cmd_i.rm_miss) begin
      status_d = ST_NOT_FOUND;
    end
    if (cmd_i.sh_write) begin
      k_d   = k_q + CW'(1);
      ptr_d = ptr_inc;
    end
    if (cmd_i.sh_finish) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      head_q         <= '0;
      cur_q          <= IDLE_RESET;
      resched_q      <= 1'b0;
      slice_length_q <= SLICE_RESET;
      idle_task_q    <= IDLE_RESET;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slice_q[i] <= SLICE_RESET;
      end
    end else begin
      count_q   <= count_d;
      head_q    <= head_d;
      cur_q     <= cur_d;
      resched_q <= resched_d;
      if (tick_we) begin
        slice_q[cur_q] <= slice_expire ? slice_length_q : slice_cur - SLICE_W'(1);
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SLICE_LENGTH: slice_length_q <= cfg_data_i[SLICE_W-1:0];
          CFG_IDLE_TASK:    idle_task_q    <= cfg_data_i[TASK_W-1:0];
          default:          idle_task_q    <= idle_task_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= op_e'(operation_i);
      tid_q      <= task_id_i;
      runnable_q <= current_runnable_i;
    end
    k_q        <= k_d;
    ptr_q      <= ptr_d;
    status_q   <= status_d;
    switched_q <= switched_d;
    if (cmd_i.out_load) begin
      running_task_o    <= cur_q;
      switched_o        <= switched_q;
      resched_pending_o <= resched_q;
      status_o          <= status_q;
    end
  end

  `include "round_robin_time_slice_scheduler_assert.svh"

  `RRTS_ASSERT_NEXT(a_switch_clears_flag, cmd_i.sw_pop, !resched_q)
  `RRTS_ASSERT_NEXT(a_enqueue_fills, cmd_i.exec && op_q == OP_ENQUEUE && !full, count_q != '0)
  `RRTS_ASSERT_SAME(a_pop_needs_entry, cmd_i.sw_pop || cmd_i.sh_finish, !empty)

endmodule

@@ design/round_robin_time_slice_scheduler.sv @@
// Top level of the round-robin time-slice scheduler.
//
//   Channel  Signals                                   Direction
//   in       in_valid_i / in_ready_o, request fields   into block
//   out      out_valid_o / out_ready_i, result fields  out of block
//   cfg      cfg_valid_i / cfg_ready_o, index, data    into block
//
// Tick, enqueue, reschedule, unused opcodes and a switch point without a pending flag pass
// through S_EXEC and S_DONE; a switch point with the flag set adds S_SW_PUSH, S_SW_SELECT
// and S_SW_POP, or skips S_SW_POP when the queue is empty at selection. Removal walks the
// queue memory: read and compare per entry searched; read and write per entry moved up.
// A new request is taken while the previous result waits in the output register.
// Reset needs no clearing pass; the queue memory holds no valid bits.
module round_robin_time_slice_scheduler
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            operation_i,
  input  logic [TASK_W-1:0]     task_id_i,
  input  logic                  current_runnable_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TASK_W-1:0]     running_task_o,
  output logic                  switched_o,
  output logic                  resched_pending_o,
  output logic [1:0]            status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .task_id_i          (task_id_i),
    .current_runnable_i (current_runnable_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .running_task_o     (running_task_o),
    .switched_o         (switched_o),
    .resched_pending_o  (resched_pending_o),
    .status_o           (status_o)
  );

endmodule

@@ tb/sv/round_robin_time_slice_scheduler_checker.sv @@
// Checker that predicts the scheduler's results and compares them on the output channel.
module round_robin_time_slice_scheduler_checker
  import rrts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [2:0]            operation_i,
  input  logic [TASK_W-1:0]     task_id_i,
  input  logic                  current_runnable_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [TASK_W-1:0]     running_task_i,
  input  logic                  switched_i,
  input  logic                  resched_pending_i,
  input  logic [1:0]            status_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [TASK_W-1:0] run_id;
    logic              switched;
    logic              resched;
    status_e           status;
  } sched_outcome_t;

  logic [TASK_W-1:0]  queue_slots [MAX_TASKS_DEF];
  int unsigned        queued;
  logic [TASK_W-1:0]  running;
  logic [SLICE_W-1:0] slice_budget [TASK_SLOTS];
  logic               resched;
  logic [SLICE_W-1:0] slice_len;
  logic [TASK_W-1:0]  idle_id;

  sched_outcome_t expected_outcomes [$];

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic bit push_task(logic [TASK_W-1:0] tid);
    if (queued >= MAX_TASKS_DEF) return 1'b0;
    queue_slots[queued] = tid;
    queued++;
    return 1'b1;
  endfunction

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < queued; i++) queue_slots[i] = queue_slots[i + 1];
    if (queued > 0) queued--;
  endfunction

  function automatic sched_outcome_t schedule_event(logic [2:0] op, logic [TASK_W-1:0] tid,
                                                    logic runnable);
    sched_outcome_t res;
    logic [TASK_W-1:0] prev;
    logic [TASK_W-1:0] next;
    bit found;
    res.switched = 1'b0;
    res.status = ST_OK;
    case (op)
      OP_TICK: begin
        if (slice_budget[running] <= 1) begin
          slice_budget[running] = slice_len;
          resched = 1'b1;
        end else begin
          slice_budget[running] = slice_budget[running] - 1'b1;
        end
      end
      OP_ENQUEUE: begin
        if (!push_task(tid)) res.status = ST_FULL;
      end
      OP_REMOVE: begin
        found = 1'b0;
        for (int unsigned i = 0; i < queued && !found; i++) begin
          if (queue_slots[i] == tid) begin
            drop_entry(i);
            found = 1'b1;
          end
        end
        if (!found) res.status = ST_NOT_FOUND;
      end
      OP_RESCHED: begin
        resched = 1'b1;
      end
      OP_SWITCH: begin
        if (resched) begin
          prev = running;
          resched = 1'b0;
          if (runnable && prev != idle_id) begin
            if (!push_task(prev)) res.status = ST_FULL;
          end
          if (queued > 0) begin
            next = queue_slots[0];
            drop_entry(0);
          end else begin
            next = idle_id;
          end
          running = next;
          res.switched = (running != prev);
        end
      end
      default: ;
    endcase
    res.run_id = running;
    res.resched = resched;
    return res;
  endfunction

  always @(posedge clk_i) begin
    sched_outcome_t want;
    if (!rst_ni) begin
      queued = 0;
      running = IDLE_RESET;
      resched = 1'b0;
      slice_len = SLICE_RESET;
      idle_id = IDLE_RESET;
      for (int i = 0; i < TASK_SLOTS; i++) slice_budget[i] = SLICE_RESET;
      expected_outcomes.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          flag_mismatch("result arrived with no request waiting");
        end else begin
          want = expected_outcomes.pop_front();
          if (running_task_i !== want.run_id)
            flag_mismatch($sformatf("running_task got %0d, expected %0d",
                                    running_task_i, want.run_id));
          if (switched_i !== want.switched)
            flag_mismatch($sformatf("switched got %0d, expected %0d", switched_i, want.switched));
          if (resched_pending_i !== want.resched)
            flag_mismatch($sformatf("resched_pending got %0d, expected %0d",
                                    resched_pending_i, want.resched));
          if (status_i !== want.status)
            flag_mismatch($sformatf("status got %0d, expected %0d", status_i, want.status));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SLICE_LENGTH: slice_len = cfg_data_i;
          CFG_IDLE_TASK:    idle_id = cfg_data_i[TASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_outcomes.push_back(schedule_event(operation_i, task_id_i, current_runnable_i));
    end
    pending_o = expected_outcomes.size();
  end

endmodule

@@ tb/sv/round_robin_time_slice_scheduler_test.sv @@
// Testbench top that drives scheduler requests and configuration and reports the verdict.
module round_robin_time_slice_scheduler_test;
  import rrts_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 65;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [PHASES-1:0][SLICE_W-1:0] SLICE_PLAN =
    {8'd7, 8'd2, 8'd4, 8'd255, 8'd0, 8'd1};
  localparam logic [PHASES-1:0][TASK_W-1:0] IDLE_PLAN =
    {4'd6, 4'd15, 4'd3, 4'd9, 4'd0, 4'd15};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [2:0]            operation_i;
  logic [TASK_W-1:0]     task_id_i;
  logic                  current_runnable_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [TASK_W-1:0]     running_task_o;
  logic                  switched_o;
  logic                  resched_pending_o;
  logic [1:0]            status_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int cycles = 0;
  int requests_sent;
  int stall_left;
  bit steady;
  bit hold_output;

  round_robin_time_slice_scheduler uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .task_id_i          (task_id_i),
    .current_runnable_i (current_runnable_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .running_task_o     (running_task_o),
    .switched_o         (switched_o),
    .resched_pending_o  (resched_pending_o),
    .status_o           (status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  round_robin_time_slice_scheduler_checker sched_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .operation_i        (operation_i),
    .task_id_i          (task_id_i),
    .current_runnable_i (current_runnable_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .running_task_i     (running_task_o),
    .switched_i         (switched_o),
    .resched_pending_i  (resched_pending_o),
    .status_i           (status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TASK_W-1:0] pick_task(logic [TASK_W-1:0] base);
    if ($urandom_range(0, 9) < 7) return base + TASK_W'($urandom_range(0, 3));
    return TASK_W'($urandom);
  endfunction

  initial begin
    out_ready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_output = 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_request(logic [2:0] op, logic [TASK_W-1:0] tid, logic runnable);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    task_id_i <= tid;
    current_runnable_i <= runnable;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    drain();
    repeat (8) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic run_sequence(logic [TASK_W-1:0] base);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat (MAX_TASKS_DEF + 1) send_request(OP_ENQUEUE, pick_task(base), 1'($urandom));
      send_request(OP_RESCHED, TASK_W'($urandom), 1'($urandom));
      send_request(OP_SWITCH, TASK_W'($urandom), 1'b1);
    end else if (pick < 16) begin
      repeat ($urandom_range(3, 10)) begin
        send_request(OP_RESCHED, TASK_W'($urandom), 1'($urandom));
        send_request(OP_SWITCH, TASK_W'($urandom), 1'($urandom));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 22)
        send_request(OP_TICK, TASK_W'($urandom), 1'($urandom));
      else if (pick < 42)
        send_request(OP_ENQUEUE, pick_task(base), 1'($urandom));
      else if (pick < 60)
        send_request(OP_REMOVE, pick_task(base), 1'($urandom));
      else if (pick < 70)
        send_request(OP_RESCHED, TASK_W'($urandom), 1'($urandom));
      else if (pick < 93)
        send_request(OP_SWITCH, TASK_W'($urandom), 1'($urandom));
      else
        send_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), TASK_W'($urandom),
                     1'($urandom));
    end
  endtask

  initial begin
    logic [TASK_W-1:0] base;
    int phase_start;
    in_valid_i = 1'b0;
    operation_i = OP_TICK;
    task_id_i = '0;
    current_runnable_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SLICE_LENGTH;
    cfg_data_i = '0;
    steady = 1'b0;
    hold_output = 1'b0;
    requests_sent = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_request(3'(c), 4'hf, 1'b1);
    send_request(OP_REMOVE, 4'h0, 1'b0);
    send_request(OP_SWITCH, 4'h0, 1'b1);
    send_request(OP_RESCHED, 4'h0, 1'b0);
    send_request(OP_SWITCH, 4'h0, 1'b1);
    send_request(OP_ENQUEUE, 4'hf, 1'b0);
    send_request(OP_ENQUEUE, 4'hf, 1'b1);
    send_request(OP_ENQUEUE, 4'h0, 1'b0);
    send_request(OP_REMOVE, 4'h9, 1'b0);
    send_request(OP_RESCHED, 4'h0, 1'b0);
    send_request(OP_SWITCH, 4'h0, 1'b1);
    send_request(OP_TICK, 4'h5, 1'b1);
    send_request(OP_RESCHED, 4'h0, 1'b0);
    send_request(OP_SWITCH, 4'h0, 1'b1);
    send_request(OP_RESCHED, 4'h0, 1'b0);
    send_request(OP_SWITCH, 4'h0, 1'b0);
    send_request(OP_REMOVE, 4'hf, 1'b1);
    repeat (11) send_request(OP_TICK, 4'h0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_SLICE_LENGTH, SLICE_PLAN[p]);
      write_reg(CFG_IDLE_TASK, CFG_DATA_W'(IDLE_PLAN[p]));
      base = TASK_W'($urandom);
      steady = (p == 1);
      phase_start = requests_sent;
      if (p == 2) begin
        hold_output = 1'b1;
        steady = 1'b1;
        repeat (12) send_request(OP_ENQUEUE, pick_task(base), 1'b1);
        steady = 1'b0;
        drain();
      end
      while (requests_sent - phase_start < PHASE_REQUESTS) run_sequence(base);
      steady = 1'b0;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/rrts_pkg.sv
design/rrts_ctrl.sv
design/rrts_dp.sv
design/round_robin_time_slice_scheduler.sv
tb/sv/round_robin_time_slice_scheduler_checker.sv
tb/sv/round_robin_time_slice_scheduler_test.sv
